FILE: hw/rtl/sert_pkg.sv
// Shared types, constants and the exp2 factor table for the saturation-excess runoff step.
package sert_pkg;

  // Depth values are unsigned Q15.16 millimeters on 31 bits
  localparam int FRAC_BITS = 16;
  localparam int WF        = 30;

  typedef logic [30:0] depth_t;

  localparam depth_t      DEPTH_MAX = '1;
  localparam logic [16:0] EXP_ONE   = 17'd65536;

  // Register reset values
  localparam logic [15:0] SHAPE_RESET     = 16'd19661;
  localparam depth_t      MEAN_CAP_RESET  = 31'd7864320;
  localparam depth_t      UPPER_CAP_RESET = 31'd1310720;
  localparam depth_t      LOWER_CAP_RESET = 31'd5242880;
  localparam depth_t      DEEP_CAP_RESET  = 31'd1310720;
  localparam depth_t      MEAN_START_RESET  = 31'd0;
  localparam depth_t      UPPER_START_RESET = 31'd0;
  localparam depth_t      LOWER_START_RESET = 31'd0;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SHAPE_EXPONENT,
    REG_MEAN_CAPACITY,
    REG_UPPER_CAPACITY,
    REG_LOWER_CAPACITY,
    REG_DEEP_CAPACITY,
    REG_MEAN_STORAGE_START,
    REG_UPPER_START,
    REG_LOWER_START
  } reg_index_t;

  // Runoff case and soil stage codes
  localparam logic [1:0] CASE_NONE    = 2'd0;
  localparam logic [1:0] CASE_FULL    = 2'd1;
  localparam logic [1:0] CASE_PARTIAL = 2'd2;
  localparam logic [1:0] STAGE_UPPER  = 2'd0;
  localparam logic [1:0] STAGE_LOWER  = 2'd1;
  localparam logic [1:0] STAGE_DEEP   = 2'd2;

  // Beat payloads
  typedef struct packed {
    depth_t precipitation;
    depth_t evaporation;
  } in_item_t;

  typedef struct packed {
    depth_t     runoff;
    logic [1:0] runoff_case;
    logic       runoff_error;
    depth_t     mean_storage;
    depth_t     point_storage;
    depth_t     upper_water;
    depth_t     lower_water;
    depth_t     deep_water;
    logic [1:0] soil_stage;
  } out_item_t;

  // Configuration values seen by the datapath
  typedef struct packed {
    logic [15:0] shape;
    depth_t      mean_cap;
    depth_t      upper_cap;
    depth_t      lower_cap;
    depth_t      deep_cap;
  } cfg_regs_t;

  // State loads from configuration writes
  typedef struct packed {
    logic   load_mean;
    logic   load_upper;
    logic   load_lower;
    depth_t value;
  } state_load_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_WMM,
    OP_INV_START,
    OP_DIV_STEP,
    OP_INV_DONE,
    OP_CASE,
    OP_RATIO_NET,
    OP_RATIO_MEAN,
    OP_POW_START,
    OP_LOG_STEP,
    OP_SCALE,
    OP_EXP_STEP,
    OP_POW_END,
    OP_PARTIAL,
    OP_UPDATE,
    OP_POINT,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   use_main_exp;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic partial;
  } dp_status_t;

  // Controller states
  typedef enum logic [4:0] {
    CS_IDLE,
    CS_WMM,
    CS_INV_START,
    CS_INV_DIV,
    CS_INV_DONE,
    CS_CASE,
    CS_NET_START,
    CS_MEAN_START,
    CS_RATIO_DIV,
    CS_POW_START,
    CS_LOG,
    CS_SCALE,
    CS_EXP,
    CS_POW_END,
    CS_PARTIAL,
    CS_UPDATE,
    CS_POINT,
    CS_RESULT
  } ctl_state_t;

  // Factors 2^(2^-i) in Q1.30, entry k used for fraction bit k (i = 30 - k)
  typedef logic [29:0][30:0] exp_table_t;

  function automatic logic [31:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem_v;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem_v = v;
    res   = '0;
    for (int k = 0; k < 32; k++) begin
      bit_v = 64'd1 << (62 - 2 * k);
      if (rem_v >= res + bit_v) begin
        rem_v = rem_v - (res + bit_v);
        res   = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
    end
    return res[31:0];
  endfunction

  function automatic exp_table_t build_exp_table();
    logic [63:0] c;
    exp_table_t  t;
    c = 64'd1 << 31;
    t = '0;
    for (int i = 1; i <= WF; i++) begin
      c = {32'd0, isqrt64(c << WF)};
      t[WF - i] = c[30:0];
    end
    return t;
  endfunction

  localparam exp_table_t EXP_FACTOR = build_exp_table();

endpackage

FILE: hw/rtl/sert_datapath.sv
// Datapath: storage state, shared multiplier, serial divider and log/exp power unit.
module sert_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  sert_pkg::dp_cmd_t      cmd,
  output sert_pkg::dp_status_t   status,
  input  sert_pkg::in_item_t     in_data,
  input  sert_pkg::cfg_regs_t    cfg,
  input  sert_pkg::state_load_t  load,
  output sert_pkg::out_item_t    out_data
);

  function automatic logic signed [35:0] ext(input logic [30:0] v);
    return $signed({5'b0, v});
  endfunction

  function automatic logic [30:0] sat36(input logic signed [35:0] v);
    logic [30:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > ext(sert_pkg::DEPTH_MAX)) begin
      res = sert_pkg::DEPTH_MAX;
    end else begin
      res = v[30:0];
    end
    return res;
  endfunction

  // Item and snapshot registers
  sert_pkg::depth_t prec, evap, wm_s, wmm;
  logic [16:0]      expm_s, expinv;

  // Catchment state
  sert_pkg::depth_t sm, sp, lu, ll, ld;

  // Step results
  logic signed [35:0] r_raw;
  logic [1:0]         rcase, stage_q;
  logic               err_q;
  sert_pkg::depth_t   r_fin;

  // Divider
  logic [30:0]      rem;
  logic [16:0]      xl, quo;
  sert_pkg::depth_t dden;
  logic             ratio_full;

  // Power unit
  logic [16:0] pexp, pw;
  logic        pow_zero, pow_one;
  logic [30:0] m, acc;
  logic [29:0] frac;
  logic [3:0]  plog;
  logic [34:0] y;

  logic [4:0]          cnt;
  sert_pkg::out_item_t out_q;

  // Net input and case decision
  logic signed [35:0] net_w;
  logic [31:0]        net_sp;
  logic               is_pos;

  assign net_w  = ext(prec) - ext(evap);
  assign is_pos = prec > evap;
  assign net_sp = {1'b0, net_w[30:0]} + {1'b0, sp};

  assign status.last    = cnt == 5'd0;
  assign status.partial = is_pos && (net_sp < {1'b0, wmm});

  // Shared multiplier operand select
  logic [34:0] mul_a;
  logic [30:0] mul_b;
  logic [65:0] prod;
  logic [34:0] n_val;

  assign n_val = {5'(5'd16 - {1'b0, plog}), 30'd0} - {5'd0, frac};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      sert_pkg::OP_WMM: begin
        mul_a = 35'(wm_s);
        mul_b = 31'(expm_s);
      end
      sert_pkg::OP_LOG_STEP: begin
        mul_a = 35'(m);
        mul_b = m;
      end
      sert_pkg::OP_SCALE: begin
        mul_a = n_val;
        mul_b = 31'(pexp);
      end
      sert_pkg::OP_EXP_STEP: begin
        mul_a = 35'(acc);
        mul_b = sert_pkg::EXP_FACTOR[cnt];
      end
      sert_pkg::OP_POINT: begin
        mul_a = 35'(wmm);
        mul_b = 31'(sert_pkg::EXP_ONE - pw);
      end
      sert_pkg::OP_PARTIAL: begin
        mul_a = 35'(wm_s);
        mul_b = 31'(pw);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 66'(mul_a) * 66'(mul_b);

  // Divider start values
  logic [47:0]      div_x;
  sert_pkg::depth_t div_d;
  logic [30:0]      div_num;

  always_comb begin
    div_x   = '0;
    div_d   = '0;
    div_num = '0;
    case (cmd.op)
      sert_pkg::OP_INV_START: begin
        div_x = 48'(33'h1_0000_0000 + 33'(expm_s >> 1));
        div_d = 31'(expm_s);
      end
      sert_pkg::OP_RATIO_NET: begin
        div_num = net_sp[30:0];
        div_x   = {net_sp, 16'd0};
        div_d   = wmm;
      end
      sert_pkg::OP_RATIO_MEAN: begin
        div_num = sm;
        div_x   = {1'b0, sm, 16'd0};
        div_d   = wm_s;
      end
      default: begin
        div_x = '0;
      end
    endcase
  end

  // Divider step
  logic [31:0] div_t;
  logic        div_ge;

  assign div_t  = {rem, xl[16]};
  assign div_ge = div_t >= {1'b0, dden};

  // Power base from the ratio, and its leading-one position
  logic [16:0] base_div;
  logic [3:0]  plog_new;
  logic [30:0] m_new;

  assign base_div = ratio_full ? 17'd0 : (sert_pkg::EXP_ONE - quo);

  always_comb begin
    plog_new = '0;
    for (int i = 0; i < 16; i++) begin
      if (base_div[i]) plog_new = 4'(i);
    end
  end

  assign m_new = {15'd0, base_div[15:0]} << (5'd30 - {1'b0, plog_new});

  // Power unit helpers
  logic [31:0] sq;
  logic [29:0] f_bits;
  logic [5:0]  pow_sh;

  assign sq     = prod[61:30];
  assign f_bits = 30'd0 - y[29:0];
  assign pow_sh = 6'(y[34:30]) + 6'(y[29:0] != 30'd0) + 6'd14;

  // Runoff and storage update
  logic               r_neg;
  sert_pkg::depth_t   r_pos;
  logic signed [35:0] r_w, w0, w0c, d_w, u1, l1, v1, vc;
  logic signed [35:0] base_r;

  assign base_r = net_w - ext(wm_s) + ext(sm);
  assign r_neg  = r_raw < 0;
  assign r_pos  = r_neg ? '0 : sat36(r_raw);
  assign r_w    = ext(r_pos);
  assign w0     = ext(sm) + net_w - r_w;
  assign w0c    = (w0 > ext(wm_s)) ? ext(wm_s) : w0;
  assign d_w    = net_w - r_w;
  assign u1     = ext(lu) + d_w;
  assign l1     = u1 + ext(ll) - ext(cfg.upper_cap);
  assign v1     = ext(ld) + l1 - ext(cfg.lower_cap);
  assign vc     = (v1 < ext(cfg.deep_cap)) ? v1 : ext(cfg.deep_cap);

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sm     <= sert_pkg::MEAN_START_RESET;
      sp     <= '0;
      lu     <= sert_pkg::UPPER_START_RESET;
      ll     <= sert_pkg::LOWER_START_RESET;
      ld     <= '0;
      wm_s   <= sert_pkg::MEAN_CAP_RESET;
      expm_s <= sert_pkg::EXP_ONE + 17'(sert_pkg::SHAPE_RESET);
      cnt    <= '0;
    end else begin
      case (cmd.op)
        sert_pkg::OP_LOAD: begin
          prec   <= in_data.precipitation;
          evap   <= in_data.evaporation;
          wm_s   <= cfg.mean_cap;
          expm_s <= sert_pkg::EXP_ONE + 17'(cfg.shape);
        end
        sert_pkg::OP_WMM: begin
          wmm <= (|prod[65:47]) ? sert_pkg::DEPTH_MAX : prod[46:16];
        end
        sert_pkg::OP_INV_START, sert_pkg::OP_RATIO_NET, sert_pkg::OP_RATIO_MEAN: begin
          rem        <= div_x[47:17];
          xl         <= div_x[16:0];
          quo        <= '0;
          dden       <= div_d;
          ratio_full <= (div_d == '0) || (div_num >= div_d);
          cnt        <= 5'd16;
        end
        sert_pkg::OP_DIV_STEP: begin
          rem <= div_ge ? 31'(div_t - {1'b0, dden}) : div_t[30:0];
          xl  <= {xl[15:0], 1'b0};
          quo <= {quo[15:0], div_ge};
          cnt <= cnt - 5'd1;
        end
        sert_pkg::OP_INV_DONE: begin
          expinv <= quo;
        end
        sert_pkg::OP_CASE: begin
          if (!is_pos) begin
            r_raw <= '0;
            rcase <= sert_pkg::CASE_NONE;
          end else if (net_sp >= {1'b0, wmm}) begin
            r_raw <= base_r;
            rcase <= sert_pkg::CASE_FULL;
          end else begin
            rcase <= sert_pkg::CASE_PARTIAL;
          end
        end
        sert_pkg::OP_POW_START: begin
          pow_zero <= base_div == 17'd0;
          pow_one  <= base_div[16];
          m        <= m_new;
          plog     <= plog_new;
          frac     <= '0;
          pexp     <= cmd.use_main_exp ? expm_s : expinv;
          cnt      <= 5'd29;
        end
        sert_pkg::OP_LOG_STEP: begin
          // Square; a result of two or more yields a one bit of the logarithm
          if (sq[31]) begin
            m         <= sq[31:1];
            frac[cnt] <= 1'b1;
          end else begin
            m <= sq[30:0];
          end
          cnt <= cnt - 5'd1;
        end
        sert_pkg::OP_SCALE: begin
          y   <= prod[50:16];
          acc <= 31'h4000_0000;
          cnt <= 5'd29;
        end
        sert_pkg::OP_EXP_STEP: begin
          if (f_bits[cnt]) acc <= prod[60:30];
          cnt <= cnt - 5'd1;
        end
        sert_pkg::OP_POW_END: begin
          if (pow_zero) begin
            pw <= '0;
          end else if (pow_one) begin
            pw <= sert_pkg::EXP_ONE;
          end else begin
            pw <= 17'(acc >> pow_sh);
          end
        end
        sert_pkg::OP_PARTIAL: begin
          r_raw <= base_r + ext(prod[46:16]);
        end
        sert_pkg::OP_UPDATE: begin
          r_fin <= r_pos;
          err_q <= r_neg;
          sm    <= sat36(w0c);
          if (u1 <= ext(cfg.upper_cap)) begin
            lu      <= sat36(u1);
            stage_q <= sert_pkg::STAGE_UPPER;
          end else if (l1 <= ext(cfg.lower_cap)) begin
            ll      <= sat36(l1);
            lu      <= cfg.upper_cap;
            stage_q <= sert_pkg::STAGE_LOWER;
          end else begin
            ld      <= sat36(vc);
            lu      <= cfg.upper_cap;
            ll      <= cfg.lower_cap;
            stage_q <= sert_pkg::STAGE_DEEP;
          end
        end
        sert_pkg::OP_POINT: begin
          sp <= prod[47] ? sert_pkg::DEPTH_MAX : prod[46:16];
        end
        sert_pkg::OP_RESULT: begin
          out_q.runoff        <= r_fin;
          out_q.runoff_case   <= rcase;
          out_q.runoff_error  <= err_q;
          out_q.mean_storage  <= sm;
          out_q.point_storage <= sp;
          out_q.upper_water   <= lu;
          out_q.lower_water   <= ll;
          out_q.deep_water    <= ld;
          out_q.soil_stage    <= stage_q;
        end
        default: begin
          cnt <= cnt;
        end
      endcase

      // Start-value writes load state; a mean storage start write also freezes the curve parameters
      if (load.load_mean) begin
        sm     <= load.value;
        wm_s   <= cfg.mean_cap;
        expm_s <= sert_pkg::EXP_ONE + 17'(cfg.shape);
      end
      if (load.load_upper) lu <= load.value;
      if (load.load_lower) ll <= load.value;
    end
  end

  assign out_data = out_q;

endmodule

FILE: hw/rtl/sert_ctrl.sv
// Controller: sequences the datapath through each step and the point storage recompute.
module sert_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  recompute,
  input  sert_pkg::dp_status_t  status,
  output sert_pkg::dp_cmd_t     cmd
);

  sert_pkg::ctl_state_t state, state_next;
  logic mode_step, mode_step_next;
  logic sel_net, sel_net_next;
  logic pending, pending_next;
  logic out_valid_q, out_valid_next;
  logic out_free, accept;

  assign out_free = !out_valid_q || !out_stall;
  assign in_stall = !(state == sert_pkg::CS_IDLE && !pending);
  assign accept   = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_next     = state;
    mode_step_next = mode_step;
    sel_net_next   = sel_net;
    unique case (state)
      sert_pkg::CS_IDLE: begin
        if (pending) begin
          state_next     = sert_pkg::CS_WMM;
          mode_step_next = 1'b0;
        end else if (in_valid) begin
          state_next     = sert_pkg::CS_WMM;
          mode_step_next = 1'b1;
        end
      end
      sert_pkg::CS_WMM:       state_next = sert_pkg::CS_INV_START;
      sert_pkg::CS_INV_START: state_next = sert_pkg::CS_INV_DIV;
      sert_pkg::CS_INV_DIV: begin
        if (status.last) state_next = sert_pkg::CS_INV_DONE;
      end
      sert_pkg::CS_INV_DONE: begin
        state_next = mode_step ? sert_pkg::CS_CASE : sert_pkg::CS_MEAN_START;
      end
      sert_pkg::CS_CASE: begin
        state_next = status.partial ? sert_pkg::CS_NET_START : sert_pkg::CS_UPDATE;
      end
      sert_pkg::CS_NET_START: begin
        state_next   = sert_pkg::CS_RATIO_DIV;
        sel_net_next = 1'b1;
      end
      sert_pkg::CS_MEAN_START: begin
        state_next   = sert_pkg::CS_RATIO_DIV;
        sel_net_next = 1'b0;
      end
      sert_pkg::CS_RATIO_DIV: begin
        if (status.last) state_next = sert_pkg::CS_POW_START;
      end
      sert_pkg::CS_POW_START: state_next = sert_pkg::CS_LOG;
      sert_pkg::CS_LOG: begin
        if (status.last) state_next = sert_pkg::CS_SCALE;
      end
      sert_pkg::CS_SCALE: state_next = sert_pkg::CS_EXP;
      sert_pkg::CS_EXP: begin
        if (status.last) state_next = sert_pkg::CS_POW_END;
      end
      sert_pkg::CS_POW_END: begin
        state_next = sel_net ? sert_pkg::CS_PARTIAL : sert_pkg::CS_POINT;
      end
      sert_pkg::CS_PARTIAL: state_next = sert_pkg::CS_UPDATE;
      sert_pkg::CS_UPDATE:  state_next = sert_pkg::CS_MEAN_START;
      sert_pkg::CS_POINT: begin
        state_next = mode_step ? sert_pkg::CS_RESULT : sert_pkg::CS_IDLE;
      end
      sert_pkg::CS_RESULT: begin
        if (out_free) state_next = sert_pkg::CS_IDLE;
      end
      default: state_next = sert_pkg::CS_IDLE;
    endcase
  end

  // Recompute request and result beat flag
  always_comb begin
    if (recompute) begin
      pending_next = 1'b1;
    end else if (state == sert_pkg::CS_IDLE) begin
      pending_next = 1'b0;
    end else begin
      pending_next = pending;
    end

    if (state == sert_pkg::CS_RESULT && out_free) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid_q;
    end
  end

  // Datapath commands
  always_comb begin
    cmd.use_main_exp = sel_net;
    unique case (state)
      sert_pkg::CS_IDLE:       cmd.op = accept ? sert_pkg::OP_LOAD : sert_pkg::OP_IDLE;
      sert_pkg::CS_WMM:        cmd.op = sert_pkg::OP_WMM;
      sert_pkg::CS_INV_START:  cmd.op = sert_pkg::OP_INV_START;
      sert_pkg::CS_INV_DIV:    cmd.op = sert_pkg::OP_DIV_STEP;
      sert_pkg::CS_INV_DONE:   cmd.op = sert_pkg::OP_INV_DONE;
      sert_pkg::CS_CASE:       cmd.op = sert_pkg::OP_CASE;
      sert_pkg::CS_NET_START:  cmd.op = sert_pkg::OP_RATIO_NET;
      sert_pkg::CS_MEAN_START: cmd.op = sert_pkg::OP_RATIO_MEAN;
      sert_pkg::CS_RATIO_DIV:  cmd.op = sert_pkg::OP_DIV_STEP;
      sert_pkg::CS_POW_START:  cmd.op = sert_pkg::OP_POW_START;
      sert_pkg::CS_LOG:        cmd.op = sert_pkg::OP_LOG_STEP;
      sert_pkg::CS_SCALE:      cmd.op = sert_pkg::OP_SCALE;
      sert_pkg::CS_EXP:        cmd.op = sert_pkg::OP_EXP_STEP;
      sert_pkg::CS_POW_END:    cmd.op = sert_pkg::OP_POW_END;
      sert_pkg::CS_PARTIAL:    cmd.op = sert_pkg::OP_PARTIAL;
      sert_pkg::CS_UPDATE:     cmd.op = sert_pkg::OP_UPDATE;
      sert_pkg::CS_POINT:      cmd.op = sert_pkg::OP_POINT;
      sert_pkg::CS_RESULT:     cmd.op = out_free ? sert_pkg::OP_RESULT : sert_pkg::OP_IDLE;
      default:                 cmd.op = sert_pkg::OP_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sert_pkg::CS_IDLE;
      mode_step   <= 1'b0;
      sel_net     <= 1'b0;
      pending     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state       <= state_next;
      mode_step   <= mode_step_next;
      sel_net     <= sel_net_next;
      pending     <= pending_next;
      out_valid_q <= out_valid_next;
    end
  end

  assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/saturation_excess_runoff_step.sv
// Top level: configuration registers, controller and datapath of the runoff step.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   in       | in_valid / in_stall   | in_data   (in_item_t)
//   out      | out_valid / out_stall | out_data  (out_item_t)
//   cfg      | cfg_write             | cfg_index, cfg_data
//
// One item at a time. The work is set by the 17-step serial divider and the two
// 30-step log and exp loops of the power unit, all on one shared multiplier; an
// item with partial-area runoff takes longer, as it runs an extra divide and power.
// After reset, and after each write of the mean storage start, a point storage
// recompute runs with in_stall high. A finished result waits in the output
// register; the next item is taken while it waits, and is held in its last cycle
// until the output frees up.
module saturation_excess_runoff_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sert_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sert_pkg::out_item_t  out_data,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [30:0]          cfg_data
);

  sert_pkg::cfg_regs_t   cfg;
  sert_pkg::state_load_t load;
  sert_pkg::dp_cmd_t     cmd;
  sert_pkg::dp_status_t  status;
  logic                  recompute;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shape     <= sert_pkg::SHAPE_RESET;
      cfg.mean_cap  <= sert_pkg::MEAN_CAP_RESET;
      cfg.upper_cap <= sert_pkg::UPPER_CAP_RESET;
      cfg.lower_cap <= sert_pkg::LOWER_CAP_RESET;
      cfg.deep_cap  <= sert_pkg::DEEP_CAP_RESET;
    end else if (cfg_write) begin
      unique case (sert_pkg::reg_index_t'(cfg_index))
        sert_pkg::REG_SHAPE_EXPONENT: cfg.shape     <= cfg_data[15:0];
        sert_pkg::REG_MEAN_CAPACITY:  cfg.mean_cap  <= cfg_data;
        sert_pkg::REG_UPPER_CAPACITY: cfg.upper_cap <= cfg_data;
        sert_pkg::REG_LOWER_CAPACITY: cfg.lower_cap <= cfg_data;
        sert_pkg::REG_DEEP_CAPACITY:  cfg.deep_cap  <= cfg_data;
        default:                      cfg.shape     <= cfg.shape;
      endcase
    end
  end

  // Start-value writes go straight into the state
  assign load.load_mean  = cfg_write &&
                           (cfg_index == sert_pkg::REG_MEAN_STORAGE_START);
  assign load.load_upper = cfg_write && (cfg_index == sert_pkg::REG_UPPER_START);
  assign load.load_lower = cfg_write && (cfg_index == sert_pkg::REG_LOWER_START);
  assign load.value      = cfg_data;
  assign recompute       = load.load_mean;

  sert_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .recompute (recompute),
    .status    (status),
    .cmd       (cmd)
  );

  sert_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (in_data),
    .cfg      (cfg),
    .load     (load),
    .out_data (out_data)
  );

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the saturation-excess runoff step.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sert_pkg::*;

  localparam longint ONE_D = 65536;
  localparam longint ONE_W = longint'(1) << 30;
  localparam longint DMAX = 64'h7FFF_FFFF;
  localparam int IDLE_LIMIT = 3000;

  // Predicts each step's result and holds the expected results
  class runoff_scoreboard;
    longint regs [8];
    longint mean_w, point_a, upper_w, lower_w, deep_w;
    longint factor [31];
    out_item_t expected_steps [$];
    int mismatches;

    function new();
      longint c;
      c = ONE_W << 1;
      for (int i = 1; i <= 30; i++) begin
        c = root(c << 30);
        factor[i] = c;
      end
      mismatches = 0;
    endfunction

    function longint sat(longint v);
      if (v < 0) return 0;
      if (v > DMAX) return DMAX;
      return v;
    endfunction

    function longint root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // 2^(f/2^30), Q2.30
    function longint exp2_fraction(longint f);
      longint acc;
      acc = ONE_W;
      for (int i = 1; i <= 30; i++)
        if (((f >> (30 - i)) & 1) != 0) acc = (acc * factor[i]) >> 30;
      return acc;
    endfunction

    // x^e via log2 / exp2, x in Q16.16, e in Q.16
    function longint power(longint x, longint e);
      longint m, t, frac, n, y, q, r, val, sh;
      int p;
      if (x <= 0) return 0;
      if (x >= ONE_D) return ONE_D;
      p = 0;
      frac = 0;
      m = x;
      for (t = m; t > 1; t = t >> 1) p++;
      m = m << (30 - p);
      for (int i = 0; i < 30; i++) begin
        m = (m * m) >> 30;
        if (m >= (ONE_W << 1)) begin
          m = m >> 1;
          frac = frac | (longint'(1) << (29 - i));
        end
      end
      n = longint'(16 - p) * ONE_W - frac;
      y = (n * e) >> 16;
      q = y >> 30;
      r = y & (ONE_W - 1);
      if (r == 0) begin
        val = ONE_W;
        sh = q;
      end else begin
        val = exp2_fraction(ONE_W - r);
        sh = q + 1;
      end
      sh = sh + 14;
      if (sh >= 63) return 0;
      return val >> sh;
    endfunction

    function longint ratio(longint num, longint den);
      if (den <= 0) return ONE_D;
      if (num <= 0) return 0;
      return (num << 16) / den;
    endfunction

    function longint exp_main();
      return 65536 + regs[REG_SHAPE_EXPONENT];
    endfunction

    function longint exp_inv();
      longint d;
      d = exp_main();
      return ((longint'(1) << 32) + (d >> 1)) / d;
    endfunction

    function longint point_max();
      return sat((regs[REG_MEAN_CAPACITY] * exp_main()) >> 16);
    endfunction

    function longint point_of_mean(longint w0);
      longint base;
      base = ONE_D - ratio(w0, regs[REG_MEAN_CAPACITY]);
      if (base < 0) base = 0;
      return sat((point_max() * (ONE_D - power(base, exp_inv()))) >> 16);
    endfunction

    function void reset_state();
      regs[0] = SHAPE_RESET;
      regs[1] = MEAN_CAP_RESET;
      regs[2] = UPPER_CAP_RESET;
      regs[3] = LOWER_CAP_RESET;
      regs[4] = DEEP_CAP_RESET;
      regs[5] = MEAN_START_RESET;
      regs[6] = UPPER_START_RESET;
      regs[7] = LOWER_START_RESET;
      mean_w = regs[5];
      point_a = point_of_mean(mean_w);
      upper_w = regs[6];
      lower_w = regs[7];
      deep_w = 0;
    endfunction

    function void write_reg(reg_index_t idx, longint value);
      regs[idx] = (idx == REG_SHAPE_EXPONENT) ? (value & 16'hFFFF) : (value & DMAX);
      case (idx)
        REG_MEAN_STORAGE_START: begin
          mean_w = regs[idx];
          point_a = point_of_mean(mean_w);
        end
        REG_UPPER_START: upper_w = regs[idx];
        REG_LOWER_START: lower_w = regs[idx];
        default: ;
      endcase
    endfunction

    // Accepted input beat: compute the step's result
    function void note_step(in_item_t it);
      longint p, e, net, wm, wmm, wum, wlm, wdm, r, w0, d, u, l, base, v;
      out_item_t res;
      p = it.precipitation;
      e = it.evaporation;
      net = p - e;
      wm = regs[REG_MEAN_CAPACITY];
      wmm = point_max();
      wum = regs[REG_UPPER_CAPACITY];
      wlm = regs[REG_LOWER_CAPACITY];
      wdm = regs[REG_DEEP_CAPACITY];
      res = '0;
      if (p <= e) begin
        r = 0;
        res.runoff_case = CASE_NONE;
      end else if (net + point_a >= wmm) begin
        r = net - wm + mean_w;
        res.runoff_case = CASE_FULL;
      end else begin
        base = ONE_D - ratio(net + point_a, wmm);
        if (base < 0) base = 0;
        r = net - wm + mean_w + ((wm * power(base, exp_main())) >> 16);
        res.runoff_case = CASE_PARTIAL;
      end
      if (r < 0) begin
        r = 0;
        res.runoff_error = 1'b1;
      end
      r = sat(r);
      // mean storage clamps at WM
      w0 = mean_w + net - r;
      if (w0 > wm) w0 = wm;
      mean_w = sat(w0);
      point_a = point_of_mean(mean_w);
      // soil layers fill in order
      d = net - r;
      u = upper_w;
      l = lower_w;
      if (u + d <= wum) begin
        upper_w = u + d;
        res.soil_stage = STAGE_UPPER;
      end else if (u + l + d - wum <= wlm) begin
        lower_w = u + l + d - wum;
        upper_w = wum;
        res.soil_stage = STAGE_LOWER;
      end else begin
        v = deep_w + u + l + d - wum - wlm;
        deep_w = (v < wdm) ? v : wdm;
        upper_w = wum;
        lower_w = wlm;
        res.soil_stage = STAGE_DEEP;
      end
      upper_w = sat(upper_w);
      lower_w = sat(lower_w);
      deep_w = sat(deep_w);
      res.runoff = r;
      res.mean_storage = mean_w;
      res.point_storage = point_a;
      res.upper_water = upper_w;
      res.lower_water = lower_w;
      res.deep_water = deep_w;
      expected_steps.push_back(res);
    endfunction

    function void check_step(out_item_t got);
      out_item_t want;
      if (expected_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result beat %h", got);
        return;
      end
      want = expected_steps.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result mismatch at %0t", $realtime);
          $display("  runoff %h/%h case %0d/%0d err %0d/%0d stage %0d/%0d",
                   want.runoff, got.runoff, want.runoff_case, got.runoff_case,
                   want.runoff_error, got.runoff_error, want.soil_stage, got.soil_stage);
          $display("  mean %h/%h point %h/%h", want.mean_storage, got.mean_storage,
                   want.point_storage, got.point_storage);
          $display("  upper %h/%h lower %h/%h deep %h/%h", want.upper_water,
                   got.upper_water, want.lower_water, got.lower_water,
                   want.deep_water, got.deep_water);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  runoff_scoreboard sb = new();
  bit quiet = 1'b0;
  bit calm = 1'b0;
  int idle_cycles = 0;
  int stall_left = 0;

  saturation_excess_runoff_step dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Receiver stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (!quiet && $urandom_range(0, calm ? 60 : 6) == 0)
      stall_left = $urandom_range(1, 16);
    out_stall <= !quiet && stall_left > 0;
  end

  // Result monitor and watchdog
  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check_step(out_data);
    if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Send one input beat, with an optional idle burst ahead of it
  task automatic send_step(longint p, longint e);
    in_item_t it;
    it.precipitation = p;
    it.evaporation = e;
    if (!quiet && $urandom_range(0, calm ? 20 : 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_step(it);
  endtask

  // Register write; caller lowers cfg_write after the last one
  task automatic write_reg(reg_index_t idx, longint value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[30:0];
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_steps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes every register; mean storage start goes last so A is rebuilt with new B, WM
  task automatic setup_phase(int k);
    longint b, wm;
    longint cap [3];
    longint start [3];
    case (k)
      0: begin
        b = 0; wm = 0;
        cap = '{0, 0, 0}; start = '{0, 0, 0};
      end
      1: begin
        b = 39321; wm = DMAX;
        cap = '{DMAX, DMAX, DMAX}; start = '{DMAX, DMAX, DMAX};
      end
      2: begin
        b = 1; wm = 1;
        cap = '{$urandom_range(0, 1 << 22), $urandom_range(0, 1 << 22),
                $urandom_range(0, 1 << 22)};
        start = '{2, 0, 0};
      end
      default: begin
        b = $urandom_range(1, 39321);
        wm = longint'($urandom_range(10, 300)) << 16;
        cap = '{longint'($urandom_range(0, 200)) << 16, longint'($urandom_range(0, 200)) << 16,
                longint'($urandom_range(0, 200)) << 16};
        start = '{(wm * $urandom_range(0, 120)) / 100, longint'($urandom_range(0, 60)) << 16,
                  longint'($urandom_range(0, 60)) << 16};
      end
    endcase
    write_reg(REG_SHAPE_EXPONENT, b);
    write_reg(REG_MEAN_CAPACITY, wm);
    write_reg(REG_UPPER_CAPACITY, cap[0]);
    write_reg(REG_LOWER_CAPACITY, cap[1]);
    write_reg(REG_DEEP_CAPACITY, cap[2]);
    write_reg(REG_UPPER_START, start[1]);
    write_reg(REG_LOWER_START, start[2]);
    write_reg(REG_MEAN_STORAGE_START, start[0]);
    cfg_write <= 1'b0;
  endtask

  task automatic random_step();
    longint p, e;
    case ($urandom_range(0, 9))
      0: begin
        p = $urandom & DMAX;
        e = $urandom & DMAX;
      end
      1: begin
        p = $urandom_range(0, 40 << 16);
        e = p + $urandom_range(0, 10 << 16);
      end
      2: begin
        p = $urandom_range(0, 40 << 16);
        e = p;
      end
      3: begin
        p = $urandom_range(0, 64);
        e = $urandom_range(0, 4);
      end
      default: begin
        p = $urandom_range(0, 100 << 16);
        e = $urandom_range(0, 10 << 16);
      end
    endcase
    send_step(p, e);
  endtask

  initial begin
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, no/full/partial runoff, tiny nets, layer spill-over
    send_step(0, 0);
    send_step(10 << 16, 10 << 16);
    send_step(0, DMAX);
    send_step(10 << 16, 0);
    send_step(1, 0);
    send_step(2, 1);
    send_step(30 << 16, 2 << 16);
    for (int i = 0; i < 6; i++) send_step(50 << 16, 1 << 16);
    send_step(DMAX, 0);
    send_step(DMAX, DMAX);
    send_step(1, 0);
    send_step(0, 5 << 16);
    send_step(3 << 16, 0);
    send_step(64'h5555_5555 & DMAX, 64'h2AAA_AAAA);
    drain();

    // Random phases over several settings, extremes first
    for (int k = 0; k < 8; k++) begin
      calm = (k % 3 == 2);
      quiet = (k == 7);
      setup_phase(k);
      for (int n = 0; n < 56; n++) random_step();
      drain();
    end

    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_steps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
